/* hdl/gsm_pkg.sv */
// Shared constants and sequencer state type for the gcd block.
`default_nettype none

package gsm_pkg;

	// Fixed width of each operand and result field on the stream ports.
	localparam int unsigned FieldWidth = 32;

	// Default internal datapath width.
	localparam int unsigned DataWidthDefault = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_MOD,
		ST_NEXT,
		ST_DONE
	} gsm_state_t;

endpackage : gsm_pkg

`default_nettype wire

/* hdl/gcd_euclid_subtract_then_modulo.sv */
// Top level: iterative Euclid gcd with a shared subtract unit and a stream interface.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one request: two unsigned
//   operands. A request is taken when s_tvalid and s_tready are both high.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one gcd per request.
//   s_tready is high only while the sequencer is idle; one request is in work
//   at a time.
//   Each Euclid round first subtracts the smaller value from the remainder up
//   to three times and then checks it; if the remainder is still not below
//   the smaller value, a restoring modulo follows that retires one dividend
//   bit per cycle. A round closes with a step that shifts the pair down.
//   All subtract and modulo steps share the one subtract-and-compare unit.
//   An operand of zero skips the rounds and goes straight to the result.
//   The result sits in an output register; the next request is taken as soon
//   as the result is loaded there, even while the receiver stalls. A new
//   result waits in the sequencer until the previous one has been taken.
//   Reset (arst_n low) returns the sequencer to idle and drops any pending
//   result.
`default_nettype none

module gcd_euclid_subtract_then_modulo #(
	parameter int unsigned DATA_WIDTH = gsm_pkg::DataWidthDefault
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// s_tdata: [31:0] operand_a, [63:32] operand_b
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [2*gsm_pkg::FieldWidth-1:0] s_tdata,
	// m_tdata: [31:0] gcd_value
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [gsm_pkg::FieldWidth-1:0]        m_tdata
);

	import gsm_pkg::*;

	localparam int unsigned W      = DATA_WIDTH;
	localparam int unsigned CW     = $clog2(DATA_WIDTH);
	localparam int unsigned ExtW   = 3 * FieldWidth;

	gsm_state_t state_q, state_nxt;

	logic [W-1:0]  big_q;     // larger value; shifts out as modulo dividend
	logic [W-1:0]  small_q;   // smaller value; holds the result at the end
	logic [W-1:0]  rem_q;     // running remainder / partial remainder
	logic [1:0]    sub_cnt_q; // subtractions done in this round
	logic [CW-1:0] bit_cnt_q; // modulo bit position
	logic          out_valid_q;
	logic [FieldWidth-1:0] out_data_q;

	// Operands resized to the datapath width (low bits kept).
	logic [ExtW-1:0] ext_a, ext_b;
	logic [W-1:0]    opa, opb, op_max, op_min;
	logic [ExtW-1:0] ext_res;

	assign ext_a  = {{(ExtW - FieldWidth){1'b0}}, s_tdata[FieldWidth-1:0]};
	assign ext_b  = {{(ExtW - FieldWidth){1'b0}}, s_tdata[2*FieldWidth-1:FieldWidth]};
	assign opa    = ext_a[W-1:0];
	assign opb    = ext_b[W-1:0];
	assign op_max = (opa > opb) ? opa : opb;
	assign op_min = (opa > opb) ? opb : opa;
	assign ext_res = {{(ExtW - W){1'b0}}, small_q};

	// Shared unit: remainder minus smaller value in the subtract rounds,
	// shifted partial remainder minus smaller value in the modulo steps.
	logic [W:0] unit_a, unit_b, unit_diff;
	logic       unit_ge;

	assign unit_a = (state_q == ST_MOD) ? {rem_q, big_q[W-1]} : {1'b0, rem_q};
	assign unit_b = {1'b0, small_q};

	gsm_sub_unit #(
		.WIDTH(W + 1)
	) u_sub (
		.minuend   (unit_a),
		.subtrahend(unit_b),
		.diff      (unit_diff),
		.ge        (unit_ge)
	);

	logic accept_in;
	logic load_out;
	logic mod_last;

	assign accept_in = s_tvalid && s_tready;
	assign mod_last  = (bit_cnt_q == CW'(DATA_WIDTH - 1));
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Next state of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					// gcd(x, 0) = x: skip straight to the result.
					state_nxt = (op_min == '0) ? ST_DONE : ST_SUB;
				end
			end
			ST_SUB: begin
				if (sub_cnt_q == 2'd3 || !(sub_cnt_q == 2'd0 || unit_ge)) begin
					// Third check still not below: fall back to full modulo.
					state_nxt = (sub_cnt_q == 2'd3 && unit_ge) ? ST_MOD : ST_NEXT;
				end
			end
			ST_MOD: begin
				if (mod_last) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_nxt = (rem_q == '0) ? ST_DONE : ST_SUB;
			end
			ST_DONE: begin
				if (load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output register: hold until taken, advance when the sequencer finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= ext_res[FieldWidth-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					big_q     <= op_max;
					// With a zero operand the larger value is the result.
					small_q   <= (op_min == '0) ? op_max : op_min;
					rem_q     <= op_max;
					sub_cnt_q <= 2'd0;
				end
			end
			ST_SUB: begin
				if (sub_cnt_q != 2'd3 && (sub_cnt_q == 2'd0 || unit_ge)) begin
					rem_q     <= unit_diff[W-1:0];
					sub_cnt_q <= sub_cnt_q + 2'd1;
				end else if (sub_cnt_q == 2'd3 && unit_ge) begin
					// Clear the partial remainder for the modulo; the dividend shifts in from big_q.
					rem_q     <= '0;
					bit_cnt_q <= '0;
				end
			end
			ST_MOD: begin
				rem_q     <= unit_ge ? unit_diff[W-1:0] : unit_a[W-1:0];
				big_q     <= {big_q[W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + CW'(1);
			end
			ST_NEXT: begin
				if (rem_q != '0) begin
					big_q     <= small_q;
					small_q   <= rem_q;
					rem_q     <= small_q;
					sub_cnt_q <= 2'd0;
				end
			end
			ST_DONE: begin
				// hold
			end
			default: begin
				// hold
			end
		endcase
	end

endmodule : gcd_euclid_subtract_then_modulo

`default_nettype wire

/* hdl/gsm_sub_unit.sv */
// Shared subtract-and-compare unit used by every subtract and modulo step of the gcd sequencer.
`default_nettype none

module gsm_sub_unit #(
	parameter int unsigned WIDTH = 33
) (
	input  wire logic [WIDTH-1:0] minuend,
	input  wire logic [WIDTH-1:0] subtrahend,
	output logic      [WIDTH-1:0] diff,
	output logic                  ge
);

	logic [WIDTH:0] full;

	// Borrow out clear means minuend >= subtrahend.
	assign full = {1'b0, minuend} - {1'b0, subtrahend};
	assign diff = full[WIDTH-1:0];
	assign ge   = ~full[WIDTH];

endmodule : gsm_sub_unit

`default_nettype wire

/* tb/gcd_checker.sv */
// Checker for the gcd block: predicts each gcd from the accepted operands and compares results.
module gcd_checker #(
	parameter int unsigned DATA_WIDTH = gsm_pkg::DataWidthDefault
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	// s_tdata: [31:0] operand_a, [63:32] operand_b
	input  wire logic [2*gsm_pkg::FieldWidth-1:0] s_tdata,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: [31:0] gcd_value
	input  wire logic [gsm_pkg::FieldWidth-1:0]   m_tdata,
	output int unsigned                           fail_count,
	output int unsigned                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FW = gsm_pkg::FieldWidth;
	localparam int unsigned MaxPrinted = 40;

	logic [FW-1:0] expected_gcds[$];

	initial fail_count = 0;
	initial pending = 0;

	// Euclid with up to three subtractions per round, modulo when those fall short.
	function automatic logic [FW-1:0] euclid_gcd(input logic [FW-1:0] op_a,
			input logic [FW-1:0] op_b);
		logic [DATA_WIDTH-1:0] x;
		logic [DATA_WIDTH-1:0] y;
		logic [DATA_WIDTH-1:0] big;
		logic [DATA_WIDTH-1:0] lesser;
		logic [DATA_WIDTH-1:0] rem;
		x = DATA_WIDTH'(op_a);
		y = DATA_WIDTH'(op_b);
		big = (x > y) ? x : y;
		lesser = (x > y) ? y : x;
		if (lesser == '0) begin
			return FW'(big);
		end
		do begin
			rem = big - lesser;
			if (rem >= lesser) begin
				rem = rem - lesser;
				if (rem >= lesser) begin
					rem = rem - lesser;
					if (rem >= lesser) begin
						rem = big % lesser;
					end
				end
			end
			big = lesser;
			lesser = rem;
		end while (rem != '0);
		return FW'(big);
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < MaxPrinted) begin
			$display("[%0t] gcd mismatch: %s", $realtime, what);
		end
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [FW-1:0] want;
		if (!arst_n) begin
			expected_gcds.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_gcds.size() == 0) begin
					report_mismatch($sformatf("result %0d with no request waiting", m_tdata));
				end else begin
					want = expected_gcds.pop_front();
					if (m_tdata !== want) begin
						report_mismatch($sformatf("gcd_value %0d, want %0d", m_tdata, want));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				// Append the prediction at the tail of the queue.
				expected_gcds = {expected_gcds,
					euclid_gcd(s_tdata[FW-1:0], s_tdata[2*FW-1:FW])};
			end
			pending = expected_gcds.size();
		end
	end

	final begin
		if (expected_gcds.size() != 0) begin
			$display("gcd results missing: %0d", expected_gcds.size());
		end
	end
endmodule

/* tb/tb.sv */
// Top of the gcd testbench: clock, reset, operand stimulus, receiver stalls and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FW = gsm_pkg::FieldWidth;
	localparam int unsigned RandomCount = 1525;
	// Receiver and sender stay busy-free for this many final requests.
	localparam int unsigned QuietTail = 150;
	// Watch this long for stray results after the last expected one.
	localparam int unsigned DrainCycles = 2000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [2*FW-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [FW-1:0]   m_tdata;
	logic            quiet = 1'b0;
	int unsigned     fail_count;
	int unsigned     pending;

	always #2 clk = ~clk;

	gcd_euclid_subtract_then_modulo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gcd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: drop ready in random stall bursts, hold ready high once quiet.
	always @(negedge clk) begin
		static int unsigned stall_left = 0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one request at a falling edge, hold it until a rising edge takes it,
	// then either keep valid high for the next one or drop it for a short burst.
	task automatic issue(input logic [FW-1:0] op_a, input logic [FW-1:0] op_b);
		s_tdata <= {op_b, op_a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Fibonacci pairs drive the longest chains of subtract-only rounds.
	function automatic logic [2*FW-1:0] fib_pair(input int unsigned k);
		logic [FW-1:0] lo;
		logic [FW-1:0] hi;
		logic [FW-1:0] nxt;
		lo = 1;
		hi = 1;
		for (int unsigned i = 0; i < k; i++) begin
			nxt = lo + hi;
			lo = hi;
			hi = nxt;
		end
		return {hi, lo};
	endfunction

	initial begin
		logic [FW-1:0]   ra;
		logic [FW-1:0]   rb;
		logic [FW-1:0]   g;
		logic [2*FW-1:0] fp;
		int unsigned     mode;

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero operands, extremes, equal values, each round shape.
		issue(32'd0, 32'd0);
		issue(32'd0, 32'd12345);
		issue(32'hFFFF_FFFF, 32'd0);
		issue(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(32'd77, 32'd77);
		issue(32'hFFFF_FFFF, 32'd1);
		issue(32'd1, 32'hFFFF_FFFF);
		issue(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		issue(32'h8000_0000, 32'h4000_0000);
		issue(32'd36, 32'd18);
		issue(32'd54, 32'd18);
		issue(32'd72, 32'd18);
		issue(32'd90, 32'd18);
		issue(32'd1000003, 32'd3);
		issue(32'd2971215073, 32'd1836311903);
		issue(32'd1836311903, 32'd2971215073);
		issue(32'hAAAA_AAAA, 32'h5555_5555);
		issue(32'h5555_5555, 32'hAAAA_AAAA);
		issue(32'd4294967291, 32'd4294967279);
		issue(32'd1, 32'd1);
		issue(32'd0, 32'd1);
		issue(32'd65536 * 32'd65521, 32'd65536 * 32'd65519);

		// Random: full-width operands for half the draws, mixed with shaped pairs.
		for (int unsigned n = 0; n < RandomCount; n++) begin
			if (n == RandomCount - QuietTail) begin
				quiet = 1'b1;
			end
			mode = $urandom_range(0, 9);
			ra = $urandom();
			rb = $urandom();
			case (mode)
				4: begin
					g = $urandom_range(1, 65535);
					ra = g * $urandom_range(1, 65535);
					rb = g * $urandom_range(1, 65535);
				end
				5: begin
					ra = $urandom_range(0, 255);
					rb = $urandom_range(0, 255);
				end
				6: begin
					if ($urandom_range(0, 1) == 0) begin
						ra = '0;
					end else begin
						rb = '0;
					end
				end
				7: begin
					rb = rb >> $urandom_range(0, 31);
					ra = rb * $urandom_range(1, 5);
				end
				8: begin
					fp = fib_pair($urandom_range(0, 45));
					ra = fp[FW-1:0];
					rb = fp[2*FW-1:FW];
				end
				9: begin
					ra = 32'hFFFF_FFFF ^ $urandom_range(0, 255);
				end
				default: begin
				end
			endcase
			issue(ra, rb);
		end
		s_tvalid <= 1'b0;

		// Drain every outstanding gcd, then watch for strays.
		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end
endmodule

/* files.f */
hdl/gsm_pkg.sv
hdl/gsm_sub_unit.sv
hdl/gcd_euclid_subtract_then_modulo.sv
tb/gcd_checker.sv
tb/tb.sv
